// ===== hw/rtl/rmpm_pkg.sv =====
// shared types and codes of the reverse multi-pattern matcher
`default_nettype none
package rmpm_pkg;

  localparam int TYPE_W = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;
  localparam int KIND_W = 3;
  localparam int END_W  = 33;
  localparam int TAG_W  = 8;
  localparam int CNT_W  = 8;
  localparam int LEN_W  = 6;

  localparam logic [TYPE_W-1:0] REQ_PAT_BYTE = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PAT_END  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_BUILD    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_TEXT     = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_BEGIN    = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_END      = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_REG      = 3'd6;

  localparam logic [BYTE_W-1:0] REG_SEL_BEGIN = 8'd0;
  localparam logic [BYTE_W-1:0] REG_SEL_END   = 8'd1;

  localparam logic [KIND_W-1:0] KIND_NOMATCH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BEGIN     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOT_BUILT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_MISUSE    = 3'd7;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [POS_W-1:0]  match_start;
    logic [END_W-1:0]  match_end;
    logic [TAG_W-1:0]  node_tag;
    logic [CNT_W-1:0]  anchor_count;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rmpm_in_if.sv =====
// request channel interface
`default_nettype none
interface rmpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rmpm_pkg::TYPE_W-1:0] req_type;
  logic [rmpm_pkg::BYTE_W-1:0] byte_value;
  logic [rmpm_pkg::POS_W-1:0]  position;

  modport source (output valid, output req_type, output byte_value, output position,
                  input ready);
  modport sink (input valid, input req_type, input byte_value, input position,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rmpm_out_if.sv =====
// result channel interface
`default_nettype none
interface rmpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmpm_pkg::KIND_W-1:0] result_kind;
  logic [rmpm_pkg::POS_W-1:0]  match_start;
  logic [rmpm_pkg::END_W-1:0]  match_end;
  logic [rmpm_pkg::TAG_W-1:0]  node_tag;
  logic [rmpm_pkg::CNT_W-1:0]  anchor_count;
  logic                        last;

  modport source (output valid, output result_kind, output match_start, output match_end,
                  output node_tag, output anchor_count, output last, input ready);
  modport sink (input valid, input result_kind, input match_start, input match_end,
                input node_tag, input anchor_count, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rmpm_out_stage.sv =====
// one-entry result register between the sequencer and the result channel
`default_nettype none
module rmpm_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rmpm_pkg::result_t res,
  output logic                   free,
  rmpm_out_if.source             out_chan
);

  logic              valid_r;
  rmpm_pkg::result_t data_r;

  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.result_kind  = data_r.result_kind;
  assign out_chan.match_start  = data_r.match_start;
  assign out_chan.match_end    = data_r.match_end;
  assign out_chan.node_tag     = data_r.node_tag;
  assign out_chan.anchor_count = data_r.anchor_count;
  assign out_chan.last         = data_r.last;

endmodule
`default_nettype wire

// ===== hw/rtl/reverse_multi_pattern_matcher_top.sv =====
// reverse multi-pattern matcher: trie build, link computation and text scan
// Requests enter on in_chan (valid/ready), one at a time; results leave on
// out_chan (valid/ready) through a one-entry output register.
// Pattern bytes (last byte first) grow the goto trie, a pattern end marks
// the node accepting, build computes fail and dictionary-suffix links
// breadth-first, text bytes (fed backwards) give one match per accepting
// node on the dictionary chain or one no-match result, last flagged.
// The trie, link, word-length and queue tables sit in single-port synchronous
// memories with a registered read. For single results the first result
// shows on out_chan in the same cycle as in_chan.ready returns. A text byte
// does a goto lookup, a fail step per miss, then a walk of the dictionary
// chain. Build first walks the 256 byte values of the root, then for each
// queued node its 256 byte values, following fail links for every child.
// After reset a clearing pass over all NODES*256 goto entries invalidates
// the goto memory and zeroes the word lengths; in_chan.ready stays low
// meanwhile.
// A stalled out_chan holds the sequencer before its next result; the input
// is taken again once the last result of a request sits in the output
// register.
`default_nettype none
module reverse_multi_pattern_matcher_top #(
  parameter int NODES   = 256,
  parameter int MAX_LEN = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmpm_in_if.sink    in_chan,
  rmpm_out_if.source out_chan
);

  localparam int NW   = $clog2(NODES);
  localparam int NC_W = NW + 1;
  localparam int GA_W = NW + rmpm_pkg::BYTE_W;
  localparam int LW   = rmpm_pkg::LEN_W;
  localparam int EW   = rmpm_pkg::END_W;
  localparam int PW   = rmpm_pkg::POS_W;
  localparam int TW   = rmpm_pkg::TAG_W;

  typedef enum logic [22:0] {
    S_CLEAR    = 23'b1 << 0,
    S_IDLE     = 23'b1 << 1,
    S_OUT      = 23'b1 << 2,
    S_PAT_CHK  = 23'b1 << 3,
    S_TXT_GO   = 23'b1 << 4,
    S_TXT_GCHK = 23'b1 << 5,
    S_TXT_FAIL = 23'b1 << 6,
    S_TXT_WL   = 23'b1 << 7,
    S_TXT_WCHK = 23'b1 << 8,
    S_B_INIT   = 23'b1 << 9,
    S_B_RRD    = 23'b1 << 10,
    S_B_RCHK   = 23'b1 << 11,
    S_B_QRD    = 23'b1 << 12,
    S_B_QCHK   = 23'b1 << 13,
    S_B_SFAIL  = 23'b1 << 14,
    S_B_GRD    = 23'b1 << 15,
    S_B_GCHK   = 23'b1 << 16,
    S_B_RGO    = 23'b1 << 17,
    S_B_RGCHK  = 23'b1 << 18,
    S_B_RFAIL  = 23'b1 << 19,
    S_B_F      = 23'b1 << 20,
    S_B_FCHK   = 23'b1 << 21,
    S_B_DONE   = 23'b1 << 22
  } state_t;

  state_t state_r, state_nxt, ret_r;
  rmpm_pkg::result_t res_r;

  logic [rmpm_pkg::BYTE_W-1:0] c_r;
  logic [PW-1:0]               pos_r;
  logic [NC_W-1:0]             node_cnt_r;
  logic [NW-1:0]               ins_r, scan_r, cur_r, s_r, fs_r, t_r, r_r, f_r;
  logic [LW-1:0]               len_r;
  logic                        built_r;
  logic [rmpm_pkg::CNT_W-1:0]  beg_cnt_r, end_cnt_r;
  logic [7:0]                  a_r;
  logic [NC_W-1:0]             head_r, tail_r;
  logic [GA_W-1:0]             clr_r;

  // memories
  logic [NW:0]   g_mem [NODES*256];
  logic [NW-1:0] f_mem [NODES];
  logic [NW:0]   x_mem [NODES];
  logic [LW-1:0] w_mem [NODES];
  logic [NW-1:0] q_mem [NODES];

  logic [GA_W-1:0] g_addr;
  logic            g_we;
  logic [NW:0]     g_wdata, g_rd_r;
  logic [NW-1:0]   f_addr, f_wdata, f_rd_r;
  logic            f_we;
  logic [NW-1:0]   x_addr;
  logic            x_we;
  logic [NW:0]     x_wdata, x_rd_r;
  logic [NW-1:0]   w_addr;
  logic            w_we;
  logic [LW-1:0]   w_wdata, w_rd_r;
  logic [NW-1:0]   q_addr, q_wdata, q_rd_r;
  logic            q_we;

  always_ff @(posedge clk) begin
    if (g_we) begin
      g_mem[g_addr] <= g_wdata;
    end
    g_rd_r <= g_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      f_mem[f_addr] <= f_wdata;
    end
    f_rd_r <= f_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_addr] <= x_wdata;
    end
    x_rd_r <= x_mem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_addr] <= w_wdata;
    end
    w_rd_r <= w_mem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_addr] <= q_wdata;
    end
    q_rd_r <= q_mem[q_addr];
  end

  logic acc, stage_free, full_ins;
  logic g_hit;
  logic [NW-1:0] g_tgt, new_id;

  assign in_chan.ready = (state_r == S_IDLE);
  assign acc      = in_chan.valid && in_chan.ready;
  assign full_ins = (len_r >= LW'(MAX_LEN));
  assign g_hit    = g_rd_r[NW];
  assign g_tgt    = g_rd_r[NW-1:0];
  assign new_id   = node_cnt_r[NW-1:0];

  function automatic logic [TW-1:0] tag_of(input logic [NW-1:0] n);
    logic [NW+TW-1:0] ext;
    ext = {{TW{1'b0}}, n};
    return ext[TW-1:0];
  endfunction

  function automatic rmpm_pkg::result_t mk_res(
    input logic [rmpm_pkg::KIND_W-1:0] k,
    input logic [PW-1:0]               s,
    input logic [EW-1:0]               e,
    input logic [TW-1:0]               t,
    input logic [rmpm_pkg::CNT_W-1:0]  n,
    input logic                        l
  );
    rmpm_pkg::result_t r;
    r.result_kind  = k;
    r.match_start  = s;
    r.match_end    = e;
    r.node_tag     = t;
    r.anchor_count = n;
    r.last         = l;
    return r;
  endfunction

  // next state and memory port control
  always_comb begin
    state_nxt = state_r;
    g_addr = '0; g_we = 1'b0; g_wdata = '0;
    f_addr = '0; f_we = 1'b0; f_wdata = '0;
    x_addr = '0; x_we = 1'b0; x_wdata = '0;
    w_addr = '0; w_we = 1'b0; w_wdata = '0;
    q_addr = '0; q_we = 1'b0; q_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        g_addr = clr_r;
        g_we   = 1'b1;
        w_addr = clr_r[NW-1:0];
        w_we   = 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        g_addr = {ins_r, in_chan.byte_value};
        w_addr = ins_r;
        w_wdata = len_r;
        if (acc) begin
          state_nxt = S_OUT;
          case (in_chan.req_type)
            rmpm_pkg::REQ_PAT_BYTE: begin
              if (!built_r && !full_ins) begin
                state_nxt = S_PAT_CHK;
              end
            end
            rmpm_pkg::REQ_PAT_END: begin
              w_we = !built_r && (len_r != '0);
            end
            rmpm_pkg::REQ_BUILD: begin
              if (!built_r) begin
                state_nxt = S_B_INIT;
              end
            end
            rmpm_pkg::REQ_TEXT: begin
              if (built_r) begin
                state_nxt = S_TXT_GO;
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (stage_free) begin
          state_nxt = ret_r;
        end
      end
      S_PAT_CHK: begin
        g_addr  = {ins_r, c_r};
        g_wdata = {1'b1, new_id};
        g_we    = !g_hit && (node_cnt_r != NC_W'(NODES));
        state_nxt = S_OUT;
      end
      S_TXT_GO: begin
        g_addr = {cur_r, c_r};
        state_nxt = S_TXT_GCHK;
      end
      S_TXT_GCHK: begin
        f_addr = cur_r;
        if (g_hit || cur_r == '0) begin
          state_nxt = S_TXT_WL;
        end else begin
          state_nxt = S_TXT_FAIL;
        end
      end
      S_TXT_FAIL: state_nxt = S_TXT_GO;
      S_TXT_WL: begin
        w_addr = cur_r;
        x_addr = cur_r;
        state_nxt = S_TXT_WCHK;
      end
      S_TXT_WCHK: begin
        if (w_rd_r == '0 && x_rd_r[NW]) begin
          state_nxt = S_TXT_WL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_B_INIT: begin
        f_addr = '0; f_we = 1'b1; f_wdata = '0;
        x_addr = '0; x_we = 1'b1; x_wdata = '0;
        state_nxt = S_B_RRD;
      end
      S_B_RRD: begin
        g_addr = {{NW{1'b0}}, a_r};
        state_nxt = S_B_RCHK;
      end
      S_B_RCHK: begin
        f_addr = g_tgt; f_wdata = '0; f_we = g_hit;
        x_addr = g_tgt; x_wdata = '0; x_we = g_hit;
        q_addr = tail_r[NW-1:0]; q_wdata = g_tgt; q_we = g_hit;
        state_nxt = (&a_r) ? S_B_QRD : S_B_RRD;
      end
      S_B_QRD: begin
        q_addr = head_r[NW-1:0];
        state_nxt = (head_r == tail_r) ? S_B_DONE : S_B_QCHK;
      end
      S_B_QCHK: begin
        f_addr = q_rd_r;
        state_nxt = S_B_SFAIL;
      end
      S_B_SFAIL: state_nxt = S_B_GRD;
      S_B_GRD: begin
        g_addr = {s_r, a_r};
        state_nxt = S_B_GCHK;
      end
      S_B_GCHK: begin
        if (g_hit) begin
          state_nxt = S_B_RGO;
        end else begin
          state_nxt = (&a_r) ? S_B_QRD : S_B_GRD;
        end
      end
      S_B_RGO: begin
        g_addr = {r_r, a_r};
        state_nxt = S_B_RGCHK;
      end
      S_B_RGCHK: begin
        f_addr = r_r;
        if (g_hit || r_r == '0) begin
          state_nxt = S_B_F;
        end else begin
          state_nxt = S_B_RFAIL;
        end
      end
      S_B_RFAIL: state_nxt = S_B_RGO;
      S_B_F: begin
        w_addr = f_r;
        x_addr = f_r;
        state_nxt = S_B_FCHK;
      end
      S_B_FCHK: begin
        f_addr = t_r; f_we = 1'b1; f_wdata = f_r;
        x_addr = t_r; x_we = 1'b1;
        x_wdata = (w_rd_r != '0) ? {1'b1, f_r} : x_rd_r;
        q_addr = tail_r[NW-1:0]; q_we = 1'b1; q_wdata = t_r;
        state_nxt = (&a_r) ? S_B_QRD : S_B_GRD;
      end
      S_B_DONE: state_nxt = S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      node_cnt_r <= NC_W'(1);
      ins_r      <= '0;
      len_r      <= '0;
      scan_r     <= '0;
      built_r    <= 1'b0;
      beg_cnt_r  <= '0;
      end_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + GA_W'(1);
        S_IDLE: begin
          if (acc) begin
            case (in_chan.req_type)
              rmpm_pkg::REQ_PAT_END: begin
                if (!built_r && len_r != '0) begin
                  ins_r <= '0;
                  len_r <= '0;
                end
              end
              rmpm_pkg::REQ_REG: begin
                if (in_chan.byte_value == rmpm_pkg::REG_SEL_BEGIN &&
                    beg_cnt_r != rmpm_pkg::CNT_MAX) begin
                  beg_cnt_r <= beg_cnt_r + 8'd1;
                end
                if (in_chan.byte_value == rmpm_pkg::REG_SEL_END &&
                    end_cnt_r != rmpm_pkg::CNT_MAX) begin
                  end_cnt_r <= end_cnt_r + 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
        S_PAT_CHK: begin
          if (g_hit) begin
            ins_r <= g_tgt;
            len_r <= len_r + LW'(1);
          end else if (node_cnt_r != NC_W'(NODES)) begin
            ins_r      <= new_id;
            len_r      <= len_r + LW'(1);
            node_cnt_r <= node_cnt_r + NC_W'(1);
          end
        end
        S_TXT_GCHK: begin
          if (g_hit) begin
            scan_r <= g_tgt;
          end else if (cur_r == '0) begin
            scan_r <= '0;
          end
        end
        S_B_DONE: begin
          built_r <= 1'b1;
          scan_r  <= '0;
          ins_r   <= '0;
          len_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers and result composition
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          c_r   <= in_chan.byte_value;
          pos_r <= in_chan.position;
          cur_r <= scan_r;
          ret_r <= S_IDLE;
          res_r <= mk_res(rmpm_pkg::KIND_MISUSE, '0, '0, '0, '0, 1'b1);
          case (in_chan.req_type)
            rmpm_pkg::REQ_PAT_BYTE: begin
              if (!built_r && full_ins) begin
                res_r <= mk_res(rmpm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
              end
            end
            rmpm_pkg::REQ_PAT_END: begin
              if (!built_r && len_r != '0) begin
                res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, tag_of(ins_r), '0, 1'b1);
              end
            end
            rmpm_pkg::REQ_BUILD: begin
              res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, '0, '0, 1'b1);
            end
            rmpm_pkg::REQ_TEXT: begin
              res_r <= mk_res(rmpm_pkg::KIND_NOT_BUILT, '0, '0, '0, '0, 1'b1);
            end
            rmpm_pkg::REQ_BEGIN: begin
              res_r <= mk_res(rmpm_pkg::KIND_BEGIN, in_chan.position,
                              {1'b0, in_chan.position}, '0, beg_cnt_r, 1'b1);
            end
            rmpm_pkg::REQ_END: begin
              res_r <= mk_res(rmpm_pkg::KIND_END, in_chan.position,
                              {1'b0, in_chan.position}, '0, end_cnt_r, 1'b1);
            end
            rmpm_pkg::REQ_REG: begin
              if (in_chan.byte_value == rmpm_pkg::REG_SEL_BEGIN) begin
                res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, '0,
                                (beg_cnt_r != rmpm_pkg::CNT_MAX) ?
                                beg_cnt_r + 8'd1 : beg_cnt_r, 1'b1);
              end else if (in_chan.byte_value == rmpm_pkg::REG_SEL_END) begin
                res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, '0,
                                (end_cnt_r != rmpm_pkg::CNT_MAX) ?
                                end_cnt_r + 8'd1 : end_cnt_r, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      S_PAT_CHK: begin
        if (g_hit) begin
          res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, tag_of(g_tgt), '0, 1'b1);
        end else if (node_cnt_r != NC_W'(NODES)) begin
          res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, tag_of(new_id), '0, 1'b1);
        end else begin
          res_r <= mk_res(rmpm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        end
      end
      S_TXT_GCHK: begin
        if (g_hit) begin
          cur_r <= g_tgt;
        end
      end
      S_TXT_FAIL: cur_r <= f_rd_r;
      S_TXT_WCHK: begin
        cur_r <= x_rd_r[NW-1:0];
        if (w_rd_r != '0) begin
          res_r <= mk_res(rmpm_pkg::KIND_MATCH, pos_r,
                          {1'b0, pos_r} + EW'(w_rd_r), tag_of(cur_r), '0, !x_rd_r[NW]);
          ret_r <= x_rd_r[NW] ? S_TXT_WL : S_IDLE;
        end else begin
          res_r <= mk_res(rmpm_pkg::KIND_NOMATCH, pos_r, {1'b0, pos_r}, '0, '0, 1'b1);
          ret_r <= S_IDLE;
        end
      end
      S_B_INIT: begin
        a_r    <= '0;
        head_r <= '0;
        tail_r <= '0;
      end
      S_B_RCHK: begin
        a_r <= a_r + 8'd1;
        if (g_hit) begin
          tail_r <= tail_r + NC_W'(1);
        end
      end
      S_B_QRD: begin
        if (head_r != tail_r) begin
          head_r <= head_r + NC_W'(1);
        end
      end
      S_B_QCHK: s_r <= q_rd_r;
      S_B_SFAIL: begin
        fs_r <= f_rd_r;
        a_r  <= '0;
      end
      S_B_GCHK: begin
        if (g_hit) begin
          t_r <= g_tgt;
          r_r <= fs_r;
        end else begin
          a_r <= a_r + 8'd1;
        end
      end
      S_B_RGCHK: begin
        f_r <= g_hit ? g_tgt : '0;
      end
      S_B_RFAIL: r_r <= f_rd_r;
      S_B_FCHK: begin
        tail_r <= tail_r + NC_W'(1);
        a_r    <= a_r + 8'd1;
      end
      S_B_DONE: begin
        res_r <= mk_res(rmpm_pkg::KIND_ACK, '0, '0, '0, '0, 1'b1);
        ret_r <= S_IDLE;
      end
      default: ;
    endcase
  end

  rmpm_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     ((state_r == S_OUT) && stage_free),
    .res      (res_r),
    .free     (stage_free),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== verif/rmpm_checker.sv =====
// checker that predicts matcher results and compares every result transaction
`timescale 1ns / 1ps
module rmpm_checker #(
  parameter int NODES   = 256,
  parameter int MAX_LEN = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rmpm_in_if        in_mon,
  rmpm_out_if       out_mon,
  output int        fails,
  output int        pending
);

  bit                          goto_v [NODES*256];
  logic [rmpm_pkg::TAG_W-1:0]  goto_t [NODES*256];
  logic [rmpm_pkg::TAG_W-1:0]  fail_of [NODES];
  bit                          sfx_v [NODES];
  logic [rmpm_pkg::TAG_W-1:0]  sfx_of [NODES];
  logic [rmpm_pkg::LEN_W-1:0]  wlen [NODES];
  int                          node_cnt;
  logic [rmpm_pkg::TAG_W-1:0]  ins_node;
  int                          ins_len;
  logic [rmpm_pkg::TAG_W-1:0]  scan_node;
  bit                          built;
  logic [rmpm_pkg::CNT_W-1:0]  begin_cnt;
  logic [rmpm_pkg::CNT_W-1:0]  end_cnt;
  rmpm_pkg::result_t           expected_results[$];

  function automatic void reset_model();
    for (int i = 0; i < NODES*256; i++) goto_v[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      wlen[i] = '0;
      sfx_v[i] = 0;
      fail_of[i] = '0;
      sfx_of[i] = '0;
    end
    node_cnt = 1;
    ins_node = '0;
    ins_len = 0;
    scan_node = '0;
    built = 0;
    begin_cnt = '0;
    end_cnt = '0;
    expected_results = {};
  endfunction

  function automatic void push_result(logic [rmpm_pkg::KIND_W-1:0] kind,
                                      logic [rmpm_pkg::POS_W-1:0] start,
                                      logic [rmpm_pkg::END_W-1:0] stop,
                                      logic [rmpm_pkg::TAG_W-1:0] tag,
                                      logic [rmpm_pkg::CNT_W-1:0] cnt, logic lst);
    rmpm_pkg::result_t r;
    r.result_kind = kind;
    r.match_start = start;
    r.match_end = stop;
    r.node_tag = tag;
    r.anchor_count = cnt;
    r.last = lst;
    expected_results = {expected_results, r};
  endfunction

  function automatic void compute_links();
    logic [rmpm_pkg::TAG_W-1:0] bfs [NODES];
    int head, tail, r, f, t, s, guard;
    head = 0;
    tail = 0;
    fail_of[0] = '0;
    sfx_v[0] = 0;
    for (int a = 0; a < 256; a++) begin
      if (goto_v[a] && tail < NODES) begin
        t = goto_t[a];
        fail_of[t] = '0;
        sfx_v[t] = 0;
        bfs[tail] = rmpm_pkg::TAG_W'(t);
        tail++;
      end
    end
    while (head < tail) begin
      s = bfs[head];
      head++;
      for (int a = 0; a < 256; a++) begin
        if (goto_v[s*256+a]) begin
          t = goto_t[s*256+a];
          r = fail_of[s];
          guard = 0;
          while (!goto_v[r*256+a] && r != 0 && guard < NODES) begin
            r = fail_of[r];
            guard++;
          end
          f = goto_v[r*256+a] ? int'(goto_t[r*256+a]) : 0;
          fail_of[t] = rmpm_pkg::TAG_W'(f);
          if (wlen[f] != 0) begin
            sfx_v[t] = 1;
            sfx_of[t] = rmpm_pkg::TAG_W'(f);
          end else begin
            sfx_v[t] = sfx_v[f];
            sfx_of[t] = sfx_of[f];
          end
          if (tail < NODES) begin
            bfs[tail] = rmpm_pkg::TAG_W'(t);
            tail++;
          end
        end
      end
    end
  endfunction

  function automatic void scan_byte(logic [rmpm_pkg::BYTE_W-1:0] c,
                                    logic [rmpm_pkg::POS_W-1:0] pos);
    int n, guard, k, sx;
    bit more, nxt;
    n = scan_node;
    guard = 0;
    k = 0;
    while (!goto_v[n*256+c] && n != 0 && guard < NODES) begin
      n = fail_of[n];
      guard++;
    end
    n = goto_v[n*256+c] ? int'(goto_t[n*256+c]) : 0;
    scan_node = rmpm_pkg::TAG_W'(n);
    if (wlen[n] != 0) begin
      push_result(rmpm_pkg::KIND_MATCH, pos,
                  {1'b0, pos} + rmpm_pkg::END_W'(wlen[n]),
                  rmpm_pkg::TAG_W'(n), '0, !sfx_v[n]);
      k++;
    end
    more = sfx_v[n];
    sx = sfx_of[n];
    while (more && k < MAX_LEN + 1) begin
      nxt = sfx_v[sx];
      push_result(rmpm_pkg::KIND_MATCH, pos,
                  {1'b0, pos} + rmpm_pkg::END_W'(wlen[sx]),
                  rmpm_pkg::TAG_W'(sx), '0, !nxt);
      k++;
      more = nxt;
      sx = sfx_of[sx];
    end
    if (k == 0) push_result(rmpm_pkg::KIND_NOMATCH, pos, {1'b0, pos}, '0, '0, 1'b1);
    else expected_results[$].last = 1'b1;
  endfunction

  function automatic void predict(logic [rmpm_pkg::TYPE_W-1:0] typ,
                                  logic [rmpm_pkg::BYTE_W-1:0] c,
                                  logic [rmpm_pkg::POS_W-1:0] pos);
    int idx;
    case (typ)
      rmpm_pkg::REQ_PAT_BYTE: begin
        idx = int'(ins_node) * 256 + c;
        if (built) push_result(rmpm_pkg::KIND_MISUSE, '0, '0, '0, '0, 1'b1);
        else if (ins_len >= MAX_LEN) push_result(rmpm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        else if (!goto_v[idx] && node_cnt >= NODES)
          push_result(rmpm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        else begin
          if (!goto_v[idx]) begin
            goto_v[idx] = 1;
            goto_t[idx] = rmpm_pkg::TAG_W'(node_cnt);
            node_cnt++;
          end
          ins_node = goto_t[idx];
          ins_len++;
          push_result(rmpm_pkg::KIND_ACK, '0, '0, ins_node, '0, 1'b1);
        end
      end
      rmpm_pkg::REQ_PAT_END: begin
        if (built || ins_len == 0) push_result(rmpm_pkg::KIND_MISUSE, '0, '0, '0, '0, 1'b1);
        else begin
          wlen[ins_node] = rmpm_pkg::LEN_W'(ins_len);
          push_result(rmpm_pkg::KIND_ACK, '0, '0, ins_node, '0, 1'b1);
          ins_node = '0;
          ins_len = 0;
        end
      end
      rmpm_pkg::REQ_BUILD: begin
        if (!built) begin
          compute_links();
          built = 1;
          scan_node = '0;
          ins_node = '0;
          ins_len = 0;
        end
        push_result(rmpm_pkg::KIND_ACK, '0, '0, '0, '0, 1'b1);
      end
      rmpm_pkg::REQ_TEXT: begin
        if (!built) push_result(rmpm_pkg::KIND_NOT_BUILT, '0, '0, '0, '0, 1'b1);
        else scan_byte(c, pos);
      end
      rmpm_pkg::REQ_BEGIN:
        push_result(rmpm_pkg::KIND_BEGIN, pos, {1'b0, pos}, '0, begin_cnt, 1'b1);
      rmpm_pkg::REQ_END:
        push_result(rmpm_pkg::KIND_END, pos, {1'b0, pos}, '0, end_cnt, 1'b1);
      rmpm_pkg::REQ_REG: begin
        if (c == rmpm_pkg::REG_SEL_BEGIN) begin
          if (begin_cnt != rmpm_pkg::CNT_MAX) begin_cnt++;
          push_result(rmpm_pkg::KIND_ACK, '0, '0, '0, begin_cnt, 1'b1);
        end else if (c == rmpm_pkg::REG_SEL_END) begin
          if (end_cnt != rmpm_pkg::CNT_MAX) end_cnt++;
          push_result(rmpm_pkg::KIND_ACK, '0, '0, '0, end_cnt, 1'b1);
        end else push_result(rmpm_pkg::KIND_MISUSE, '0, '0, '0, '0, 1'b1);
      end
      default: push_result(rmpm_pkg::KIND_MISUSE, '0, '0, '0, '0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    rmpm_pkg::result_t got, want;
    if (!rst_n) begin
      reset_model();
      fails = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict(in_mon.req_type, in_mon.byte_value, in_mon.position);
      if (out_mon.valid && out_mon.ready) begin
        got.result_kind = out_mon.result_kind;
        got.match_start = out_mon.match_start;
        got.match_end = out_mon.match_end;
        got.node_tag = out_mon.node_tag;
        got.anchor_count = out_mon.anchor_count;
        got.last = out_mon.last;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time,
                     want.result_kind, got.result_kind);
            fails++;
          end
          if (got.match_start !== want.match_start) begin
            $display("%0t: match_start expected %h actual %h", $time,
                     want.match_start, got.match_start);
            fails++;
          end
          if (got.match_end !== want.match_end) begin
            $display("%0t: match_end expected %h actual %h", $time,
                     want.match_end, got.match_end);
            fails++;
          end
          if (got.node_tag !== want.node_tag) begin
            $display("%0t: node_tag expected %0d actual %0d", $time,
                     want.node_tag, got.node_tag);
            fails++;
          end
          if (got.anchor_count !== want.anchor_count) begin
            $display("%0t: anchor_count expected %0d actual %0d", $time,
                     want.anchor_count, got.anchor_count);
            fails++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            fails++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// top of the matcher testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [rmpm_pkg::TYPE_W-1:0] REQ_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycles = 0;
  bit   steady;
  int   hold_ticket;
  int   hold_seen = 0;
  int   hold_left = 0;

  rmpm_in_if  in_chan ();
  rmpm_out_if out_chan ();

  reverse_multi_pattern_matcher_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rmpm_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stalls, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= 400;
      out_chan.ready <= 0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  task automatic send(logic [rmpm_pkg::TYPE_W-1:0] typ, logic [rmpm_pkg::BYTE_W-1:0] c,
                      logic [rmpm_pkg::POS_W-1:0] pos);
    while (!steady && $urandom_range(99) < 32) begin
      in_chan.valid <= 0;
      @(negedge clk);
    end
    in_chan.valid <= 1;
    in_chan.req_type <= typ;
    in_chan.byte_value <= c;
    in_chan.position <= pos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pattern(logic [rmpm_pkg::BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) send(rmpm_pkg::REQ_PAT_BYTE, bytes[i], $urandom);
    send(rmpm_pkg::REQ_PAT_END, 8'($urandom), $urandom);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [rmpm_pkg::BYTE_W-1:0] text_char();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(3));
  endfunction

  initial begin
    logic [rmpm_pkg::BYTE_W-1:0] pat[$];
    int sel;
    hold_ticket = 0;
    steady = 0;
    in_chan.valid = 0;
    in_chan.req_type = '0;
    in_chan.byte_value = '0;
    in_chan.position = '0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed part, before and after build
    send(rmpm_pkg::REQ_TEXT, "a", 32'h1);
    send(rmpm_pkg::REQ_BEGIN, 8'($urandom), 32'h0);
    send(rmpm_pkg::REQ_END, 8'($urandom), 32'hFFFF_FFFF);
    send(rmpm_pkg::REQ_REG, rmpm_pkg::REG_SEL_BEGIN, $urandom);
    send(rmpm_pkg::REQ_REG, rmpm_pkg::REG_SEL_END, $urandom);
    send(rmpm_pkg::REQ_REG, 8'hFF, $urandom);
    send(rmpm_pkg::REQ_REG, 8'd2, $urandom);
    send(REQ_UNUSED, 8'($urandom), $urandom);
    send(rmpm_pkg::REQ_PAT_END, 8'($urandom), $urandom);
    send_pattern('{"a"});
    send_pattern('{"a", "b"});
    send_pattern('{"b", "a"});
    send_pattern('{"a", "b", "c"});
    send_pattern('{"b", "c"});
    send_pattern('{"c", "a", "b"});
    send_pattern('{"a", "a"});
    send_pattern('{"d", "a", "b", "c", "a"});
    // longer than the maximum length
    pat = {};
    for (int i = 0; i < 34; i++) pat = {pat, 8'("a" + (i % 4))};
    send_pattern(pat);
    // unterminated pattern left open at build
    send(rmpm_pkg::REQ_PAT_BYTE, "z", $urandom);
    drain();
    send(rmpm_pkg::REQ_BUILD, 8'($urandom), $urandom);
    send(rmpm_pkg::REQ_BUILD, 8'($urandom), $urandom);
    send(rmpm_pkg::REQ_PAT_BYTE, "a", $urandom);
    send(rmpm_pkg::REQ_PAT_END, 8'($urandom), $urandom);
    send(rmpm_pkg::REQ_TEXT, "c", 32'hFFFF_FFFF);
    send(rmpm_pkg::REQ_TEXT, "b", 32'hFFFF_FFFE);
    send(rmpm_pkg::REQ_TEXT, "a", 32'h0);
    send(rmpm_pkg::REQ_TEXT, 8'h00, 32'h5);
    send(rmpm_pkg::REQ_TEXT, 8'hFF, 32'h6);
    send(rmpm_pkg::REQ_BEGIN, 8'($urandom), $urandom);
    drain();

    // random part
    for (int i = 0; i < 140; i++) begin
      if (i == 40) hold_ticket = hold_ticket + 1;
      if (i == 70) drain();
      steady = (i >= 90 && i < 120);
      sel = $urandom_range(99);
      if (sel < 75) send(rmpm_pkg::REQ_TEXT, text_char(), $urandom);
      else if (sel < 80) send(rmpm_pkg::REQ_BEGIN, 8'($urandom), $urandom);
      else if (sel < 85) send(rmpm_pkg::REQ_END, 8'($urandom), $urandom);
      else if (sel < 92) send(rmpm_pkg::REQ_REG, 8'($urandom_range(2)), $urandom);
      else send(3'($urandom), 8'($urandom), $urandom);
    end
    steady = 0;
    drain();
    repeat (600) @(negedge clk);

    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rmpm_pkg.sv
hw/rtl/rmpm_in_if.sv
hw/rtl/rmpm_out_if.sv
hw/rtl/rmpm_out_stage.sv
hw/rtl/reverse_multi_pattern_matcher_top.sv
verif/rmpm_checker.sv
verif/testbench.sv
